### hw/rtl/aes_kx_pkg.sv
// ----------------------------------------------------------------------------
// aes_kx_pkg
// Shared types, constants and lookup functions for the AES key expansion
// block: sequencer states, register indexes, S-box and round constants.
// ----------------------------------------------------------------------------
package aes_kx_pkg;

   localparam int unsigned WORD_WIDTH     = 32;
   localparam int unsigned KEY_WORDS_MAX  = 8;
   localparam int unsigned KEY_WORDS_MIN  = 4;
   localparam int unsigned ROUNDS_MAX     = 14;
   localparam int unsigned ROUNDS_MIN     = 10;
   localparam int unsigned RCON_COUNT     = 10;
   localparam int unsigned CSR_WIDTH      = 4;
   localparam int unsigned CSR_IDX_WIDTH  = 1;
   localparam int unsigned INDEX_WIDTH    = 6;
   localparam int unsigned WIN_IDX_WIDTH  = $clog2(KEY_WORDS_MAX);
   localparam int unsigned RCON_IDX_WIDTH = $clog2(RCON_COUNT + 1);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_KEY_WORDS = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_ROUNDS    = 1'b1;

   localparam logic [CSR_WIDTH-1:0] KEY_WORDS_RESET = 4'd4;
   localparam logic [CSR_WIDTH-1:0] ROUNDS_RESET    = 4'd10;

   // position within a key-word period that takes the extra S-box on long keys
   localparam logic [WIN_IDX_WIDTH-1:0] SUB_ONLY_POS  = 3'd4;
   localparam logic [CSR_WIDTH-1:0]     SUB_ONLY_MINK = 4'd6;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } kx_state_type;

   function automatic logic [7:0] sbox(input logic [7:0] a);
      logic [7:0] r;
      unique case (a)
         8'h00: r = 8'h63; 8'h01: r = 8'h7c; 8'h02: r = 8'h77; 8'h03: r = 8'h7b;
         8'h04: r = 8'hf2; 8'h05: r = 8'h6b; 8'h06: r = 8'h6f; 8'h07: r = 8'hc5;
         8'h08: r = 8'h30; 8'h09: r = 8'h01; 8'h0a: r = 8'h67; 8'h0b: r = 8'h2b;
         8'h0c: r = 8'hfe; 8'h0d: r = 8'hd7; 8'h0e: r = 8'hab; 8'h0f: r = 8'h76;
         8'h10: r = 8'hca; 8'h11: r = 8'h82; 8'h12: r = 8'hc9; 8'h13: r = 8'h7d;
         8'h14: r = 8'hfa; 8'h15: r = 8'h59; 8'h16: r = 8'h47; 8'h17: r = 8'hf0;
         8'h18: r = 8'had; 8'h19: r = 8'hd4; 8'h1a: r = 8'ha2; 8'h1b: r = 8'haf;
         8'h1c: r = 8'h9c; 8'h1d: r = 8'ha4; 8'h1e: r = 8'h72; 8'h1f: r = 8'hc0;
         8'h20: r = 8'hb7; 8'h21: r = 8'hfd; 8'h22: r = 8'h93; 8'h23: r = 8'h26;
         8'h24: r = 8'h36; 8'h25: r = 8'h3f; 8'h26: r = 8'hf7; 8'h27: r = 8'hcc;
         8'h28: r = 8'h34; 8'h29: r = 8'ha5; 8'h2a: r = 8'he5; 8'h2b: r = 8'hf1;
         8'h2c: r = 8'h71; 8'h2d: r = 8'hd8; 8'h2e: r = 8'h31; 8'h2f: r = 8'h15;
         8'h30: r = 8'h04; 8'h31: r = 8'hc7; 8'h32: r = 8'h23; 8'h33: r = 8'hc3;
         8'h34: r = 8'h18; 8'h35: r = 8'h96; 8'h36: r = 8'h05; 8'h37: r = 8'h9a;
         8'h38: r = 8'h07; 8'h39: r = 8'h12; 8'h3a: r = 8'h80; 8'h3b: r = 8'he2;
         8'h3c: r = 8'heb; 8'h3d: r = 8'h27; 8'h3e: r = 8'hb2; 8'h3f: r = 8'h75;
         8'h40: r = 8'h09; 8'h41: r = 8'h83; 8'h42: r = 8'h2c; 8'h43: r = 8'h1a;
         8'h44: r = 8'h1b; 8'h45: r = 8'h6e; 8'h46: r = 8'h5a; 8'h47: r = 8'ha0;
         8'h48: r = 8'h52; 8'h49: r = 8'h3b; 8'h4a: r = 8'hd6; 8'h4b: r = 8'hb3;
         8'h4c: r = 8'h29; 8'h4d: r = 8'he3; 8'h4e: r = 8'h2f; 8'h4f: r = 8'h84;
         8'h50: r = 8'h53; 8'h51: r = 8'hd1; 8'h52: r = 8'h00; 8'h53: r = 8'hed;
         8'h54: r = 8'h20; 8'h55: r = 8'hfc; 8'h56: r = 8'hb1; 8'h57: r = 8'h5b;
         8'h58: r = 8'h6a; 8'h59: r = 8'hcb; 8'h5a: r = 8'hbe; 8'h5b: r = 8'h39;
         8'h5c: r = 8'h4a; 8'h5d: r = 8'h4c; 8'h5e: r = 8'h58; 8'h5f: r = 8'hcf;
         8'h60: r = 8'hd0; 8'h61: r = 8'hef; 8'h62: r = 8'haa; 8'h63: r = 8'hfb;
         8'h64: r = 8'h43; 8'h65: r = 8'h4d; 8'h66: r = 8'h33; 8'h67: r = 8'h85;
         8'h68: r = 8'h45; 8'h69: r = 8'hf9; 8'h6a: r = 8'h02; 8'h6b: r = 8'h7f;
         8'h6c: r = 8'h50; 8'h6d: r = 8'h3c; 8'h6e: r = 8'h9f; 8'h6f: r = 8'ha8;
         8'h70: r = 8'h51; 8'h71: r = 8'ha3; 8'h72: r = 8'h40; 8'h73: r = 8'h8f;
         8'h74: r = 8'h92; 8'h75: r = 8'h9d; 8'h76: r = 8'h38; 8'h77: r = 8'hf5;
         8'h78: r = 8'hbc; 8'h79: r = 8'hb6; 8'h7a: r = 8'hda; 8'h7b: r = 8'h21;
         8'h7c: r = 8'h10; 8'h7d: r = 8'hff; 8'h7e: r = 8'hf3; 8'h7f: r = 8'hd2;
         8'h80: r = 8'hcd; 8'h81: r = 8'h0c; 8'h82: r = 8'h13; 8'h83: r = 8'hec;
         8'h84: r = 8'h5f; 8'h85: r = 8'h97; 8'h86: r = 8'h44; 8'h87: r = 8'h17;
         8'h88: r = 8'hc4; 8'h89: r = 8'ha7; 8'h8a: r = 8'h7e; 8'h8b: r = 8'h3d;
         8'h8c: r = 8'h64; 8'h8d: r = 8'h5d; 8'h8e: r = 8'h19; 8'h8f: r = 8'h73;
         8'h90: r = 8'h60; 8'h91: r = 8'h81; 8'h92: r = 8'h4f; 8'h93: r = 8'hdc;
         8'h94: r = 8'h22; 8'h95: r = 8'h2a; 8'h96: r = 8'h90; 8'h97: r = 8'h88;
         8'h98: r = 8'h46; 8'h99: r = 8'hee; 8'h9a: r = 8'hb8; 8'h9b: r = 8'h14;
         8'h9c: r = 8'hde; 8'h9d: r = 8'h5e; 8'h9e: r = 8'h0b; 8'h9f: r = 8'hdb;
         8'ha0: r = 8'he0; 8'ha1: r = 8'h32; 8'ha2: r = 8'h3a; 8'ha3: r = 8'h0a;
         8'ha4: r = 8'h49; 8'ha5: r = 8'h06; 8'ha6: r = 8'h24; 8'ha7: r = 8'h5c;
         8'ha8: r = 8'hc2; 8'ha9: r = 8'hd3; 8'haa: r = 8'hac; 8'hab: r = 8'h62;
         8'hac: r = 8'h91; 8'had: r = 8'h95; 8'hae: r = 8'he4; 8'haf: r = 8'h79;
         8'hb0: r = 8'he7; 8'hb1: r = 8'hc8; 8'hb2: r = 8'h37; 8'hb3: r = 8'h6d;
         8'hb4: r = 8'h8d; 8'hb5: r = 8'hd5; 8'hb6: r = 8'h4e; 8'hb7: r = 8'ha9;
         8'hb8: r = 8'h6c; 8'hb9: r = 8'h56; 8'hba: r = 8'hf4; 8'hbb: r = 8'hea;
         8'hbc: r = 8'h65; 8'hbd: r = 8'h7a; 8'hbe: r = 8'hae; 8'hbf: r = 8'h08;
         8'hc0: r = 8'hba; 8'hc1: r = 8'h78; 8'hc2: r = 8'h25; 8'hc3: r = 8'h2e;
         8'hc4: r = 8'h1c; 8'hc5: r = 8'ha6; 8'hc6: r = 8'hb4; 8'hc7: r = 8'hc6;
         8'hc8: r = 8'he8; 8'hc9: r = 8'hdd; 8'hca: r = 8'h74; 8'hcb: r = 8'h1f;
         8'hcc: r = 8'h4b; 8'hcd: r = 8'hbd; 8'hce: r = 8'h8b; 8'hcf: r = 8'h8a;
         8'hd0: r = 8'h70; 8'hd1: r = 8'h3e; 8'hd2: r = 8'hb5; 8'hd3: r = 8'h66;
         8'hd4: r = 8'h48; 8'hd5: r = 8'h03; 8'hd6: r = 8'hf6; 8'hd7: r = 8'h0e;
         8'hd8: r = 8'h61; 8'hd9: r = 8'h35; 8'hda: r = 8'h57; 8'hdb: r = 8'hb9;
         8'hdc: r = 8'h86; 8'hdd: r = 8'hc1; 8'hde: r = 8'h1d; 8'hdf: r = 8'h9e;
         8'he0: r = 8'he1; 8'he1: r = 8'hf8; 8'he2: r = 8'h98; 8'he3: r = 8'h11;
         8'he4: r = 8'h69; 8'he5: r = 8'hd9; 8'he6: r = 8'h8e; 8'he7: r = 8'h94;
         8'he8: r = 8'h9b; 8'he9: r = 8'h1e; 8'hea: r = 8'h87; 8'heb: r = 8'he9;
         8'hec: r = 8'hce; 8'hed: r = 8'h55; 8'hee: r = 8'h28; 8'hef: r = 8'hdf;
         8'hf0: r = 8'h8c; 8'hf1: r = 8'ha1; 8'hf2: r = 8'h89; 8'hf3: r = 8'h0d;
         8'hf4: r = 8'hbf; 8'hf5: r = 8'he6; 8'hf6: r = 8'h42; 8'hf7: r = 8'h68;
         8'hf8: r = 8'h41; 8'hf9: r = 8'h99; 8'hfa: r = 8'h2d; 8'hfb: r = 8'h0f;
         8'hfc: r = 8'hb0; 8'hfd: r = 8'h54; 8'hfe: r = 8'hbb; 8'hff: r = 8'h16;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

   function automatic logic [WORD_WIDTH-1:0] sub_word(input logic [WORD_WIDTH-1:0] w);
      return {sbox(w[31:24]), sbox(w[23:16]), sbox(w[15:8]), sbox(w[7:0])};
   endfunction

   // round constant for the n-th use; zero past the tenth
   function automatic logic [7:0] rcon(input logic [RCON_IDX_WIDTH-1:0] n);
      logic [7:0] r;
      unique case (n)
         4'd0:    r = 8'h01;
         4'd1:    r = 8'h02;
         4'd2:    r = 8'h04;
         4'd3:    r = 8'h08;
         4'd4:    r = 8'h10;
         4'd5:    r = 8'h20;
         4'd6:    r = 8'h40;
         4'd7:    r = 8'h80;
         4'd8:    r = 8'h1b;
         4'd9:    r = 8'h36;
         default: r = 8'h00;
      endcase
      return r;
   endfunction

endpackage

### hw/rtl/aes_key_expansion.sv
// after a key beat, ST_RUN puts the first round-key word in the output register
// throughput: one word per cycle while the result side does not stall, from a shared
//   S-box word unit over an 8-word window; 4*(rounds+1) words (44 to 60) per key
// the key channel is ready again once the last word sits in the output register
// reset: synchronous, active high; key_words returns to 4, rounds to 10, outputs go idle
// ----------------------------------------------------------------------------
// aes_key_expansion
// AES-128/192/256 key schedule: takes one key beat and emits the expanded
// round-key words in order, one result beat per word.
// ----------------------------------------------------------------------------
module aes_key_expansion (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_we,
   input  logic [aes_kx_pkg::CSR_IDX_WIDTH-1:0]  csr_index,
   input  logic [aes_kx_pkg::CSR_WIDTH-1:0]      csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w0,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w1,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w2,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w3,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w4,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w5,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w6,
   input  logic [aes_kx_pkg::WORD_WIDTH-1:0]     req_key_w7,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [aes_kx_pkg::INDEX_WIDTH-1:0]    rsp_word_index,
   output logic [aes_kx_pkg::WORD_WIDTH-1:0]     rsp_round_key_word,
   output logic                                  rsp_last_word,
   output logic                                  rsp_config_error
);

   localparam int unsigned KW  = aes_kx_pkg::KEY_WORDS_MAX;
   localparam int unsigned WW  = aes_kx_pkg::WORD_WIDTH;
   localparam int unsigned CW  = aes_kx_pkg::CSR_WIDTH;
   localparam int unsigned PW  = aes_kx_pkg::WIN_IDX_WIDTH;
   localparam int unsigned IW  = aes_kx_pkg::INDEX_WIDTH;
   localparam int unsigned RW  = aes_kx_pkg::RCON_IDX_WIDTH;

   aes_kx_pkg::kx_state_type state_ff, state_in;

   logic [CW-1:0]        key_words_ff, rounds_ff;
   logic [WW-1:0]        key_ff [KW];
   logic [WW-1:0]        key_in [KW];
   logic [WW-1:0]        win_ff [KW];
   logic [WW-1:0]        win_in [KW];
   logic [PW-1:0]        pos_ff, pos_in;
   logic                 copy_ff, copy_in;
   logic [IW-1:0]        idx_ff, idx_in;
   logic [RW-1:0]        rcon_idx_ff, rcon_idx_in;
   logic                 err_ff, err_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IW-1:0]        rsp_index_ff, rsp_index_in;
   logic [WW-1:0]        rsp_word_ff, rsp_word_in;
   logic                 rsp_last_ff, rsp_last_in;
   logic                 rsp_err_ff, rsp_err_in;

   logic [CW-1:0]        nk;
   logic [CW-1:0]        nr;
   logic [IW-1:0]        last_idx;
   logic [PW-1:0]        nk_m1;
   logic [WW-1:0]        prev_word;
   logic [WW-1:0]        sub_in;
   logic [WW-1:0]        sub_out;
   logic [WW-1:0]        temp;
   logic [WW-1:0]        new_word;
   logic                 rcon_hit;
   logic                 can_load;

   // clamp the registers to the supported range
   always_comb begin
      priority if (key_words_ff < CW'(aes_kx_pkg::KEY_WORDS_MIN)) begin
         nk = CW'(aes_kx_pkg::KEY_WORDS_MIN);
      end else if (key_words_ff > CW'(aes_kx_pkg::KEY_WORDS_MAX)) begin
         nk = CW'(aes_kx_pkg::KEY_WORDS_MAX);
      end else begin
         nk = key_words_ff;
      end
      priority if (rounds_ff < CW'(aes_kx_pkg::ROUNDS_MIN)) begin
         nr = CW'(aes_kx_pkg::ROUNDS_MIN);
      end else if (rounds_ff > CW'(aes_kx_pkg::ROUNDS_MAX)) begin
         nr = CW'(aes_kx_pkg::ROUNDS_MAX);
      end else begin
         nr = rounds_ff;
      end
      nk_m1    = PW'(nk - CW'(1));
      last_idx = IW'({nr, 2'b11});
   end

   // shared word unit: S-box of the (rotated) previous word
   always_comb begin
      prev_word = win_ff[0];
      rcon_hit  = 1'b0;
      sub_in    = prev_word;
      if (pos_ff == '0) begin
         sub_in = {prev_word[7:0], prev_word[WW-1:8]};
      end
      sub_out   = aes_kx_pkg::sub_word(sub_in);
      temp      = prev_word;
      if (pos_ff == '0) begin
         rcon_hit = 1'b1;
         temp     = sub_out ^ WW'(aes_kx_pkg::rcon(rcon_idx_ff));
      end else if (nk > aes_kx_pkg::SUB_ONLY_MINK && pos_ff == aes_kx_pkg::SUB_ONLY_POS) begin
         temp = sub_out;
      end
      new_word = copy_ff ? key_ff[0] : (win_ff[nk_m1] ^ temp);
   end

   always_comb begin
      state_in     = state_ff;
      key_in       = key_ff;
      win_in       = win_ff;
      pos_in       = pos_ff;
      copy_in      = copy_ff;
      idx_in       = idx_ff;
      rcon_idx_in  = rcon_idx_ff;
      err_in       = err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_index_in = rsp_index_ff;
      rsp_word_in  = rsp_word_ff;
      rsp_last_in  = rsp_last_ff;
      rsp_err_in   = rsp_err_ff;
      req_ready    = 1'b0;
      can_load     = !rsp_valid_ff || rsp_ready;

      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         aes_kx_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               key_in      = '{req_key_w0, req_key_w1, req_key_w2, req_key_w3,
                               req_key_w4, req_key_w5, req_key_w6, req_key_w7};
               pos_in      = '0;
               copy_in     = 1'b1;
               idx_in      = '0;
               rcon_idx_in = '0;
               err_in      = 1'b0;
               state_in    = aes_kx_pkg::ST_RUN;
            end
         end
         aes_kx_pkg::ST_RUN: begin
            if (can_load) begin
               logic err_now;
               err_now = err_ff;
               if (!copy_ff && rcon_hit) begin
                  if (rcon_idx_ff >= RW'(aes_kx_pkg::RCON_COUNT)) begin
                     err_now = 1'b1;
                  end else begin
                     rcon_idx_in = rcon_idx_ff + RW'(1);
                  end
               end
               err_in = err_now;
               for (int j = KW - 1; j > 0; j--) begin
                  win_in[j] = win_ff[j-1];
                  key_in[j-1] = key_ff[j];
               end
               win_in[0] = new_word;
               if (pos_ff == nk_m1) begin
                  pos_in  = '0;
                  copy_in = 1'b0;
               end else begin
                  pos_in = pos_ff + PW'(1);
               end
               idx_in       = idx_ff + IW'(1);
               rsp_valid_in = 1'b1;
               rsp_index_in = idx_ff;
               rsp_word_in  = new_word;
               rsp_last_in  = (idx_ff == last_idx);
               rsp_err_in   = err_now;
               if (idx_ff == last_idx) begin
                  state_in = aes_kx_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = aes_kx_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= aes_kx_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         key_words_ff <= aes_kx_pkg::KEY_WORDS_RESET;
         rounds_ff    <= aes_kx_pkg::ROUNDS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_index)
               aes_kx_pkg::CSR_KEY_WORDS: key_words_ff <= csr_wdata;
               aes_kx_pkg::CSR_ROUNDS:    rounds_ff    <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff       <= key_in;
      win_ff       <= win_in;
      pos_ff       <= pos_in;
      copy_ff      <= copy_in;
      idx_ff       <= idx_in;
      rcon_idx_ff  <= rcon_idx_in;
      err_ff       <= err_in;
      rsp_index_ff <= rsp_index_in;
      rsp_word_ff  <= rsp_word_in;
      rsp_last_ff  <= rsp_last_in;
      rsp_err_ff   <= rsp_err_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_word_index     = rsp_index_ff;
   assign rsp_round_key_word = rsp_word_ff;
   assign rsp_last_word      = rsp_last_ff;
   assign rsp_config_error   = rsp_err_ff;

endmodule

### hw/rtl/aes_kx_checker.sv
// ----------------------------------------------------------------------------
// aes_kx_checker
// Port-level checks on the key expansion block, bound to the top level.
// ----------------------------------------------------------------------------
module aes_kx_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic [aes_kx_pkg::INDEX_WIDTH-1:0]  rsp_word_index,
   input logic [aes_kx_pkg::WORD_WIDTH-1:0]   rsp_round_key_word,
   input logic                                rsp_last_word,
   input logic                                rsp_config_error
);

   // no result beat right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result beat shown right after reset");

   // a stalled result beat holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_round_key_word)
         && $stable(rsp_word_index) && $stable(rsp_last_word))
      else $error("stalled result beat changed");

   // a key beat starts a schedule, so no second key right after
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("key channel ready right after a key beat");

   // a non-final word on show means the schedule is still running
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last_word |-> !req_ready)
      else $error("key channel ready in the middle of a schedule");

   // the first word is a key copy and never flags an error
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_word_index == '0 |-> !rsp_config_error)
      else $error("error flagged on the first word");

endmodule

bind aes_key_expansion aes_kx_checker u_aes_kx_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_word_index     (rsp_word_index),
   .rsp_round_key_word (rsp_round_key_word),
   .rsp_last_word      (rsp_last_word),
   .rsp_config_error   (rsp_config_error)
);

### bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives key beats into the AES key expansion block under a range of key
// lengths and round counts, including out-of-range settings and schedules
// that run past the tenth round constant. Every round-key word is checked
// against a schedule computed here from the accepted key and the current
// register values, with random idling on both channels and one long result
// stall that backs up the key channel.
// ----------------------------------------------------------------------------
module testbench;

   localparam int unsigned WW = aes_kx_pkg::WORD_WIDTH;
   localparam int unsigned KW = aes_kx_pkg::KEY_WORDS_MAX;
   localparam int unsigned IW = aes_kx_pkg::INDEX_WIDTH;
   localparam int unsigned CW = aes_kx_pkg::CSR_WIDTH;
   localparam int unsigned XW = aes_kx_pkg::CSR_IDX_WIDTH;

   localparam int WATCHDOG_LIMIT = 5000;
   localparam int HOLD_CYCLES    = 400;
   localparam int HOLD_AFTER     = 1500;

   localparam logic [0:255][7:0] SBOX_LUT = {
      128'h637c777bf26b6fc53001672bfed7ab76, 128'hca82c97dfa5947f0add4a2af9ca472c0,
      128'hb7fd9326363ff7cc34a5e5f171d83115, 128'h04c723c31896059a071280e2eb27b275,
      128'h09832c1a1b6e5aa0523bd6b329e32f84, 128'h53d100ed20fcb15b6acbbe394a4c58cf,
      128'hd0efaafb434d338545f9027f503c9fa8, 128'h51a3408f929d38f5bcb6da2110fff3d2,
      128'hcd0c13ec5f974417c4a77e3d645d1973, 128'h60814fdc222a908846eeb814de5e0bdb,
      128'he0323a0a4906245cc2d3ac629195e479, 128'he7c8376d8dd54ea96c56f4ea657aae08,
      128'hba78252e1ca6b4c6e8dd741f4bbd8b8a, 128'h703eb5664803f60e613557b986c11d9e,
      128'he1f8981169d98e949b1e87e9ce5528df, 128'h8ca1890dbfe6426841992d0fb054bb16
   };
   localparam logic [0:9][7:0] RCON_LUT = {
      8'h01, 8'h02, 8'h04, 8'h08, 8'h10, 8'h20, 8'h40, 8'h80, 8'h1b, 8'h36
   };

   typedef logic [KW-1:0][WW-1:0] key_block_type;

   typedef struct packed {
      logic [IW-1:0] word_index;
      logic [WW-1:0] round_key_word;
      logic          last_word;
      logic          config_error;
   } round_key_beat_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            csr_we = 1'b0;
   logic [XW-1:0]   csr_index = aes_kx_pkg::CSR_KEY_WORDS;
   logic [CW-1:0]   csr_wdata = '0;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [WW-1:0]   req_key_w0 = '0;
   logic [WW-1:0]   req_key_w1 = '0;
   logic [WW-1:0]   req_key_w2 = '0;
   logic [WW-1:0]   req_key_w3 = '0;
   logic [WW-1:0]   req_key_w4 = '0;
   logic [WW-1:0]   req_key_w5 = '0;
   logic [WW-1:0]   req_key_w6 = '0;
   logic [WW-1:0]   req_key_w7 = '0;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [IW-1:0]   rsp_word_index;
   logic [WW-1:0]   rsp_round_key_word;
   logic            rsp_last_word;
   logic            rsp_config_error;

   key_block_type      key_q[$];
   round_key_beat_type round_key_q[$];
   logic [CW-1:0] cfg_key_words = aes_kx_pkg::KEY_WORDS_RESET;
   logic [CW-1:0] cfg_rounds    = aes_kx_pkg::ROUNDS_RESET;
   int   send_idle_pct = 14;
   int   recv_idle_pct = 68;
   int   fail_count    = 0;
   int   rsp_total     = 0;
   int   stall_cycles  = 0;
   int   hold_left     = 0;
   logic hold_done     = 1'b0;
   logic key_beat      = 1'b0;

   aes_key_expansion dut (
      .clock              (clock),
      .reset              (reset),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_key_w0         (req_key_w0),
      .req_key_w1         (req_key_w1),
      .req_key_w2         (req_key_w2),
      .req_key_w3         (req_key_w3),
      .req_key_w4         (req_key_w4),
      .req_key_w5         (req_key_w5),
      .req_key_w6         (req_key_w6),
      .req_key_w7         (req_key_w7),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_word_index     (rsp_word_index),
      .rsp_round_key_word (rsp_round_key_word),
      .rsp_last_word      (rsp_last_word),
      .rsp_config_error   (rsp_config_error)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic logic [WW-1:0] sbox_word(input logic [WW-1:0] x);
      return {SBOX_LUT[x[31:24]], SBOX_LUT[x[23:16]], SBOX_LUT[x[15:8]], SBOX_LUT[x[7:0]]};
   endfunction

   // full schedule for one key under the current register values
   task automatic expand_key(input key_block_type key);
      logic [WW-1:0]         w [60];
      logic [WW-1:0]         t;
      logic [7:0]            rc;
      int unsigned           nk, nr, total, rcon_n;
      logic                  err;
      round_key_beat_type    beat;
      nk = cfg_key_words;
      if (nk < aes_kx_pkg::KEY_WORDS_MIN) nk = aes_kx_pkg::KEY_WORDS_MIN;
      else if (nk > aes_kx_pkg::KEY_WORDS_MAX) nk = aes_kx_pkg::KEY_WORDS_MAX;
      nr = cfg_rounds;
      if (nr < aes_kx_pkg::ROUNDS_MIN) nr = aes_kx_pkg::ROUNDS_MIN;
      else if (nr > aes_kx_pkg::ROUNDS_MAX) nr = aes_kx_pkg::ROUNDS_MAX;
      total = 4 * (nr + 1);
      rcon_n = 0;
      err = 1'b0;
      for (int i = 0; i < total; i++) begin
         if (i < nk) begin
            w[i] = key[i];
         end else begin
            t = w[i-1];
            if (i % nk == 0) begin
               if (rcon_n < aes_kx_pkg::RCON_COUNT) begin
                  rc = RCON_LUT[rcon_n];
               end else begin
                  rc = '0;
                  err = 1'b1;
               end
               rcon_n++;
               t = sbox_word({t[7:0], t[31:8]}) ^ {24'd0, rc};
            end else if (nk > 6 && i % nk == 4) begin
               t = sbox_word(t);
            end
            w[i] = w[i-nk] ^ t;
         end
         beat.word_index     = IW'(i);
         beat.round_key_word = w[i];
         beat.last_word      = (i + 1 == total);
         beat.config_error   = err;
         round_key_q.push_back(beat);
      end
   endtask

   function automatic key_block_type random_key();
      key_block_type k;
      for (int i = 0; i < KW; i++) begin
         case ($urandom_range(9, 0))
            0:       k[i] = '0;
            1:       k[i] = '1;
            default: k[i] = $urandom;
         endcase
      end
      return k;
   endfunction

   // key driver
   always @(negedge clock) begin
      if (!req_valid || key_beat) begin
         if (key_q.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
            req_valid  <= 1'b1;
            req_key_w0 <= key_q[0][0];
            req_key_w1 <= key_q[0][1];
            req_key_w2 <= key_q[0][2];
            req_key_w3 <= key_q[0][3];
            req_key_w4 <= key_q[0][4];
            req_key_w5 <= key_q[0][5];
            req_key_w6 <= key_q[0][6];
            req_key_w7 <= key_q[0][7];
            void'(key_q.pop_front());
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // result receiver, with one long hold-off while a key waits
   always @(negedge clock) begin
      if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else if (!hold_done && rsp_total >= HOLD_AFTER && req_valid) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99, 0) >= recv_idle_pct);
      end
   end

   // monitor and checker
   always @(posedge clock) begin
      round_key_beat_type exp_beat;
      key_beat <= !reset && req_valid && req_ready;
      stall_cycles = stall_cycles + 1;
      if (!reset && req_valid && req_ready) begin
         expand_key({req_key_w7, req_key_w6, req_key_w5, req_key_w4,
                     req_key_w3, req_key_w2, req_key_w1, req_key_w0});
         stall_cycles = 0;
      end
      if (!reset && rsp_valid && rsp_ready) begin
         stall_cycles = 0;
         rsp_total <= rsp_total + 1;
         if (round_key_q.size() == 0) begin
            fail_count++;
            if (fail_count <= 10)
               $display("%0t: result beat with nothing expected: idx %0d word %h",
                        $realtime, rsp_word_index, rsp_round_key_word);
         end else begin
            exp_beat = round_key_q.pop_front();
            if (rsp_word_index !== exp_beat.word_index
                || rsp_round_key_word !== exp_beat.round_key_word
                || rsp_last_word !== exp_beat.last_word
                || rsp_config_error !== exp_beat.config_error) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("%0t: exp idx %0d %h last %b err %b, got idx %0d %h last %b err %b",
                           $realtime, exp_beat.word_index, exp_beat.round_key_word,
                           exp_beat.last_word, exp_beat.config_error, rsp_word_index,
                           rsp_round_key_word, rsp_last_word, rsp_config_error);
            end
         end
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("testbench failed");
         $finish;
      end
   end

   task automatic drain();
      while (key_q.size() > 0 || req_valid || round_key_q.size() > 0)
         @(posedge clock);
   endtask

   task automatic write_csr(input logic [XW-1:0] idx,
                            input logic [CW-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      if (idx == aes_kx_pkg::CSR_KEY_WORDS) cfg_key_words = value;
      else cfg_rounds = value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic set_schedule(input logic [CW-1:0] kw, input logic [CW-1:0] nr);
      drain();
      repeat (4) @(negedge clock);
      write_csr(aes_kx_pkg::CSR_KEY_WORDS, kw);
      write_csr(aes_kx_pkg::CSR_ROUNDS, nr);
   endtask

   initial begin
      key_block_type ramp;
      logic [CW-1:0] kw, nr;
      ramp = {32'h1f1e1d1c, 32'h1b1a1918, 32'h17161514, 32'h13121110,
              32'h0f0e0d0c, 32'h0b0a0908, 32'h07060504, 32'h03020100};
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: reset values first, then nominal, long-key and out-of-range settings
      key_q.push_back('0);
      key_q.push_back('1);
      key_q.push_back(ramp);
      set_schedule(4'd6, 4'd12);
      key_q.push_back('1);
      key_q.push_back(ramp);
      key_q.push_back({8{32'h55555555}});
      set_schedule(4'd8, 4'd14);
      key_q.push_back('0);
      key_q.push_back(ramp);
      key_q.push_back({4{32'haaaaaaaa, 32'h55555555}});
      // round constants run out in the first three of these settings
      set_schedule(4'd4, 4'd14);
      key_q.push_back(random_key());
      set_schedule(4'd4, 4'd11);
      key_q.push_back(random_key());
      set_schedule(4'd5, 4'd14);
      key_q.push_back(random_key());
      set_schedule(4'd7, 4'd13);
      key_q.push_back(random_key());
      // clamped register values, then the reset values again
      set_schedule(4'd0, 4'd0);
      key_q.push_back(random_key());
      set_schedule(4'd15, 4'd15);
      key_q.push_back(random_key());
      set_schedule(4'd3, 4'd9);
      key_q.push_back(random_key());
      set_schedule(4'd4, 4'd10);
      key_q.push_back({8{32'h55555555}});

      for (int mode = 0; mode < 3; mode++) begin
         drain();
         @(posedge clock);
         send_idle_pct = (mode == 0) ? 14 : (mode == 1) ? 68 : 0;
         recv_idle_pct = (mode == 0) ? 68 : (mode == 1) ? 14 : 0;
         for (int g = 0; g < 5; g++) begin
            if ($urandom_range(9, 0) < 6) begin
               case ($urandom_range(2, 0))
                  0:       kw = 4'd4;
                  1:       kw = 4'd6;
                  default: kw = 4'd8;
               endcase
               nr = 4'($urandom_range(aes_kx_pkg::ROUNDS_MAX, aes_kx_pkg::ROUNDS_MIN));
            end else begin
               kw = 4'($urandom_range(15, 0));
               nr = 4'($urandom_range(15, 0));
            end
            set_schedule(kw, nr);
            for (int n = 0; n < 6; n++)
               key_q.push_back(random_key());
         end
      end

      drain();
      repeat (8) @(posedge clock);
      if (fail_count == 0 && round_key_q.size() == 0)
         $display("testbench passed");
      else
         $display("testbench failed");
      $finish;
   end

endmodule
